@@ hw/rtl/p2a_pkg.sv @@
// ----------------------------------------------------------------------------
// p2a_pkg: shared constants and types for the pixel to glyph converter
// Grey weights, glyph codes, table type and the records passed between the
// top level and the glyph select pipeline.
// ----------------------------------------------------------------------------
package p2a_pkg;

	// number of printable glyphs in the grey table (2 to 128)
	localparam int GLYPH_COUNT = 94;

	// field widths
	localparam int ENTRY_INDEX_W = 7;
	localparam int GREY_W        = 8;
	localparam int COLOR_W       = 8;
	localparam int GLYPH_W       = 7;

	// the select tree is padded to every code the index field can carry
	localparam int TREE_LEAVES = 1 << ENTRY_INDEX_W;

	// grey conversion: (B*1868 + G*9617 + R*4899 + 8192) >> 14
	localparam int WEIGHT_W = 14;
	localparam int PROD_W   = COLOR_W + WEIGHT_W;
	localparam logic [WEIGHT_W-1:0] W_BLUE     = 14'd1868;
	localparam logic [WEIGHT_W-1:0] W_GREEN    = 14'd9617;
	localparam logic [WEIGHT_W-1:0] W_RED      = 14'd4899;
	localparam logic [PROD_W-1:0]   GREY_ROUND = 22'd8192;

	// glyph codes
	localparam logic [GREY_W-1:0]  WHITE_GREY  = 8'd255;
	localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 7'd32;
	localparam logic [GLYPH_W-1:0] FIRST_GLYPH = 7'd33;

	// item kinds on the input channel
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef logic [GREY_W-1:0] grey_tab_t [GLYPH_COUNT];

	// pixel entering the select pipeline
	typedef struct packed {
		logic              valid;
		logic [GREY_W-1:0] grey;
	} sel_in_t;

	// registered result leaving the select pipeline
	typedef struct packed {
		logic               valid;
		logic [GLYPH_W-1:0] glyph;
	} sel_out_t;

endpackage

@@ hw/rtl/p2a_select.sv @@
// ----------------------------------------------------------------------------
// p2a_select: nearest grey glyph search
// Absolute differences against every table entry, then a registered
// minimum tree (two compare levels per stage, one in the last) down to one
// glyph code, or the space code for white.
// ----------------------------------------------------------------------------
module p2a_select (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  p2a_pkg::sel_in_t  sel_in,
	input  p2a_pkg::grey_tab_t grey_tab,
	output p2a_pkg::sel_out_t sel_out
);
	import p2a_pkg::*;

	// one candidate: distance (bit 8 marks padding) and table index
	typedef struct packed {
		logic [GREY_W:0]          gap;
		logic [ENTRY_INDEX_W-1:0] idx;
	} cand_t;

	localparam logic [GREY_W:0] PAD_DIST = {1'b1, {GREY_W{1'b0}}};

	localparam int N1 = TREE_LEAVES / 2;
	localparam int N2 = TREE_LEAVES / 4;
	localparam int N3 = TREE_LEAVES / 8;
	localparam int N4 = TREE_LEAVES / 16;
	localparam int N5 = TREE_LEAVES / 32;
	localparam int N6 = TREE_LEAVES / 64;

	// lower index wins a tie
	function automatic cand_t pick(input cand_t a, input cand_t b);
		return (b.gap < a.gap) ? b : a;
	endfunction

	// stage 3: absolute distances
	logic              v_s3;
	logic              white_s3;
	logic [GREY_W-1:0] dist_s3 [GLYPH_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= sel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			white_s3 <= (sel_in.grey == WHITE_GREY);
			for (int i = 0; i < GLYPH_COUNT; i++) begin
				dist_s3[i] <= (grey_tab[i] > sel_in.grey) ? (grey_tab[i] - sel_in.grey)
				                                          : (sel_in.grey - grey_tab[i]);
			end
		end
	end

	// leaves, padded past the table with a distance no entry can reach
	cand_t leaf [TREE_LEAVES];

	for (genvar gi = 0; gi < TREE_LEAVES; gi++) begin : g_leaf
		if (gi < GLYPH_COUNT) begin : g_used
			assign leaf[gi] = '{gap: {1'b0, dist_s3[gi]}, idx: ENTRY_INDEX_W'(gi)};
		end else begin : g_pad
			assign leaf[gi] = '{gap: PAD_DIST, idx: ENTRY_INDEX_W'(gi)};
		end
	end

	// stage 4: levels one and two
	cand_t lvl1 [N1];
	cand_t lvl2 [N2];
	cand_t best_s4 [N2];
	logic  v_s4, white_s4;

	always_comb begin
		for (int i = 0; i < N1; i++) lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
		for (int i = 0; i < N2; i++) lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
	end

	// stage 5: levels three and four
	cand_t lvl3 [N3];
	cand_t lvl4 [N4];
	cand_t best_s5 [N4];
	logic  v_s5, white_s5;

	always_comb begin
		for (int i = 0; i < N3; i++) lvl3[i] = pick(best_s4[2*i], best_s4[2*i+1]);
		for (int i = 0; i < N4; i++) lvl4[i] = pick(lvl3[2*i], lvl3[2*i+1]);
	end

	// stage 6: levels five and six
	cand_t lvl5 [N5];
	cand_t lvl6 [N6];
	cand_t best_s6 [N6];
	logic  v_s6, white_s6;

	always_comb begin
		for (int i = 0; i < N5; i++) lvl5[i] = pick(best_s5[2*i], best_s5[2*i+1]);
		for (int i = 0; i < N6; i++) lvl6[i] = pick(lvl5[2*i], lvl5[2*i+1]);
	end

	// stage 7: last level and glyph code
	cand_t              last;
	logic               v_s7;
	logic [GLYPH_W-1:0] glyph_s7;

	assign last = pick(best_s6[0], best_s6[1]);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// tree payload
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s4  <= lvl2;
			best_s5  <= lvl4;
			best_s6  <= lvl6;
			white_s4 <= white_s3;
			white_s5 <= white_s4;
			white_s6 <= white_s5;
			glyph_s7 <= white_s6 ? SPACE_GLYPH : (last.idx + FIRST_GLYPH);
		end
	end

	assign sel_out = '{valid: v_s7, glyph: glyph_s7};

endmodule

@@ hw/rtl/pixel_to_ascii_glyph.sv @@
// ----------------------------------------------------------------------------
// pixel_to_ascii_glyph: pixel to nearest grey ASCII glyph
// Converts BGR pixels to grey and picks the printable character whose
// loaded grey level is nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries two kinds of transfer.
//   mode = load writes entry_value into grey table slot entry_index
//   (slots at or past the table size are ignored) and gives no result.
//   mode = pixel converts blue/green/red to grey and gives one glyph on the
//   output channel (glyph_valid/glyph_ready): 32 for white, else 33 + slot
//   of the nearest table entry, lowest slot on a tie.
//   Load every slot before the first pixel; unwritten slots read as garbage.
//   The path from input transfer to glyph_valid runs through seven
//   register stages: multiply, grey sum, distance, three stages of a
//   two-level minimum tree and a last compare that forms the glyph code.
//   Unless stalled, one item is taken per cycle; all stages share one enable.
//   When the receiver stalls with a glyph pending, the whole pipeline
//   holds and item_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the grey table is not cleared.
// ----------------------------------------------------------------------------
module pixel_to_ascii_glyph (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 mode,
	input  logic [p2a_pkg::ENTRY_INDEX_W-1:0]    entry_index,
	input  logic [p2a_pkg::GREY_W-1:0]           entry_value,
	input  logic [p2a_pkg::COLOR_W-1:0]          blue,
	input  logic [p2a_pkg::COLOR_W-1:0]          green,
	input  logic [p2a_pkg::COLOR_W-1:0]          red,
	output logic                                 glyph_valid,
	input  logic                                 glyph_ready,
	output logic [p2a_pkg::GLYPH_W-1:0]          glyph
);
	import p2a_pkg::*;

	logic      adv;
	sel_in_t   sel_in;
	sel_out_t  sel_out;
	grey_tab_t tab_q;
	logic      tab_we;

	// whole pipeline moves unless a finished glyph is stuck
	assign adv        = !sel_out.valid || glyph_ready;
	assign item_ready = adv;

	// stage 1: weighted products
	logic                     v_s1, pix_s1;
	logic [ENTRY_INDEX_W-1:0] idx_s1;
	logic [GREY_W-1:0]        val_s1;
	logic [PROD_W-1:0]        prod_b_s1, prod_g_s1, prod_r_s1;

	// stage 2: grey level
	logic                     v_s2, pix_s2;
	logic [ENTRY_INDEX_W-1:0] idx_s2;
	logic [GREY_W-1:0]        val_s2;
	logic [GREY_W-1:0]        grey_s2;
	logic [PROD_W-1:0]        grey_sum;

	assign grey_sum = prod_b_s1 + prod_g_s1 + prod_r_s1 + GREY_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= (mode == MODE_PIXEL);
			idx_s1    <= entry_index;
			val_s1    <= entry_value;
			prod_b_s1 <= PROD_W'(blue)  * PROD_W'(W_BLUE);
			prod_g_s1 <= PROD_W'(green) * PROD_W'(W_GREEN);
			prod_r_s1 <= PROD_W'(red)   * PROD_W'(W_RED);
			pix_s2    <= pix_s1;
			idx_s2    <= idx_s1;
			val_s2    <= val_s1;
			grey_s2   <= grey_sum[PROD_W-1:WEIGHT_W];
		end
	end

	// table write as a load leaves stage 2, in order with pixels read there
	assign tab_we = adv && v_s2 && !pix_s2 &&
	                ({1'b0, idx_s2} < (ENTRY_INDEX_W+1)'(GLYPH_COUNT));

	always_ff @(posedge clk) begin
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			if (tab_we && (idx_s2 == ENTRY_INDEX_W'(i))) tab_q[i] <= val_s2;
		end
	end

	assign sel_in = '{valid: v_s2 && pix_s2, grey: grey_s2};

	p2a_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.sel_in   (sel_in),
		.grey_tab (tab_q),
		.sel_out  (sel_out)
	);

	assign glyph_valid = sel_out.valid;
	assign glyph       = sel_out.glyph;

	// glyph codes stay printable or space
	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		glyph_valid |-> ((GLYPH_COUNT > 95) ||
		                 ((glyph >= SPACE_GLYPH) && (glyph != {GLYPH_W{1'b1}}))))
		else $error("glyph code out of printable range");

	// a stall freezes the front stages
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(v_s2) && $stable(grey_s2)))
		else $error("front stages moved during stall");

	// a result can only appear after the pipeline advanced
	a_rise_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(glyph_valid) |-> $past(adv))
		else $error("glyph_valid rose without pipeline advance");

endmodule

@@ tb/tb_pixel_to_ascii_glyph.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_to_ascii_glyph: self-checking bench for the pixel to glyph block
// Loads the grey table in several shapes, sends directed and random pixels,
// and predicts each glyph from a private copy of the table. Both channels
// stall at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_pixel_to_ascii_glyph;
	import p2a_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 24;
	localparam int IDLE_PCT    = 27;

	typedef enum int {SHAPE_RANDOM, SHAPE_RAMP, SHAPE_FLAT} table_shape_e;

	// one pending input transfer, or a marker that waits for the pipe to drain
	typedef struct {
		bit                       drain;
		logic                     kind;
		logic [ENTRY_INDEX_W-1:0] idx;
		logic [GREY_W-1:0]        val;
		logic [COLOR_W-1:0]       b;
		logic [COLOR_W-1:0]       g;
		logic [COLOR_W-1:0]       r;
	} work_item_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     item_valid  = 1'b0;
	logic                     item_ready;
	logic                     mode        = MODE_LOAD;
	logic [ENTRY_INDEX_W-1:0] entry_index = '0;
	logic [GREY_W-1:0]        entry_value = '0;
	logic [COLOR_W-1:0]       blue        = '0;
	logic [COLOR_W-1:0]       green       = '0;
	logic [COLOR_W-1:0]       red         = '0;
	logic                     glyph_valid;
	logic                     glyph_ready = 1'b0;
	logic [GLYPH_W-1:0]       glyph;

	work_item_t         pending_items[$];
	logic [GLYPH_W-1:0] glyph_expect[$];
	logic [GREY_W-1:0]  grey_shadow[GLYPH_COUNT];

	int  error_count    = 0;
	int  items_accepted = 0;
	int  loads_taken    = 0;
	int  loads_dropped  = 0;
	int  pixels_taken   = 0;
	int  glyphs_seen    = 0;
	int  white_glyphs   = 0;
	int  hold_left      = 0;
	bit  held_off       = 1'b0;
	bit  calm;

	pixel_to_ascii_glyph dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.mode        (mode),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.glyph_valid (glyph_valid),
		.glyph_ready (glyph_ready),
		.glyph       (glyph)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// no random stalls on either side for a stretch of transfers
	assign calm = (items_accepted >= 300) && (items_accepted < 380);

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// nearest table entry to the pixel's grey, lowest slot on a tie
	function automatic logic [GLYPH_W-1:0] nearest_glyph(input logic [COLOR_W-1:0] b,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
		int unsigned sum;
		int unsigned grey;
		int unsigned best;
		int unsigned best_d;
		int unsigned d;
		sum = int'(b) * int'(W_BLUE) + int'(g) * int'(W_GREEN) + int'(r) * int'(W_RED)
			+ int'(GREY_ROUND);
		grey = sum >> WEIGHT_W;
		if (grey > int'(WHITE_GREY))
			grey = int'(WHITE_GREY);
		if (grey == int'(WHITE_GREY))
			return SPACE_GLYPH;
		best = 0;
		best_d = (grey_shadow[0] > grey) ? grey_shadow[0] - grey : grey - grey_shadow[0];
		for (int i = 1; i < GLYPH_COUNT; i++) begin
			d = (grey_shadow[i] > grey) ? grey_shadow[i] - grey : grey - grey_shadow[i];
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return GLYPH_W'(best + int'(FIRST_GLYPH));
	endfunction

	// update the shadow table or queue the expected glyph for one accepted item
	task automatic absorb_item();
		if (mode == MODE_LOAD) begin
			if (entry_index < GLYPH_COUNT) begin
				grey_shadow[entry_index] = entry_value;
				loads_taken++;
			end else begin
				loads_dropped++;
			end
		end else begin
			glyph_expect = {glyph_expect, nearest_glyph(blue, green, red)};
			pixels_taken++;
		end
	endtask

	// stimulus builders
	task automatic push_load(input int idx, input int val);
		work_item_t w;
		w = '{drain: 1'b0, kind: MODE_LOAD, idx: ENTRY_INDEX_W'(idx), val: GREY_W'(val),
			b: COLOR_W'($urandom), g: COLOR_W'($urandom), r: COLOR_W'($urandom)};
		pending_items = {pending_items, w};
	endtask

	task automatic push_pixel(input int b, input int g, input int r);
		work_item_t w;
		w = '{drain: 1'b0, kind: MODE_PIXEL, idx: ENTRY_INDEX_W'($urandom),
			val: GREY_W'($urandom), b: COLOR_W'(b), g: COLOR_W'(g), r: COLOR_W'(r)};
		pending_items = {pending_items, w};
	endtask

	// equal components give exactly that grey level
	task automatic push_grey(input int level);
		push_pixel(level, level, level);
	endtask

	task automatic push_drain();
		work_item_t w;
		w = '{drain: 1'b1, kind: MODE_LOAD, idx: '0, val: '0, b: '0, g: '0, r: '0};
		pending_items = {pending_items, w};
	endtask

	task automatic load_table(input table_shape_e shape, input int level);
		int val;
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			case (shape)
				SHAPE_RANDOM: val = $urandom_range(0, 255);
				SHAPE_RAMP:   val = (i * 255) / (GLYPH_COUNT - 1);
				default:      val = level;
			endcase
			push_load(i, val);
		end
	endtask

	// stimulus: directed pixels on a sparse table, then random phases
	initial begin : build_stimulus
		int pick;
		load_table(SHAPE_FLAT, 0);
		push_load(50, 200);
		push_load(60, 220);
		push_load(GLYPH_COUNT - 1, 255);
		push_grey(0);                // all-zero entries tie: first glyph
		push_grey(210);              // equidistant between two entries
		push_grey(254);              // nearest is the last glyph
		push_grey(255);              // white
		push_pixel(255, 255, 253);
		push_pixel(255, 0, 0);
		push_pixel(0, 255, 0);
		push_pixel(0, 0, 255);
		push_pixel(255, 255, 255);
		push_pixel(0, 0, 0);
		// loads past the table must not disturb it
		push_load(GLYPH_COUNT, 0);
		push_load(127, 0);
		push_grey(254);
		push_grey(200);
		// a load right behind a pixel must not reach back into it
		push_grey(210);
		push_load(60, 211);
		push_grey(210);
		push_load(50, 255);
		push_grey(255);
		push_grey(240);
		push_drain();

		for (int k = 0; k < 100; k++) begin
			case (k)
				0:  load_table(SHAPE_RAMP, 0);
				50: begin
					push_drain();
					load_table(SHAPE_RANDOM, 0);
				end
				default: ;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 15)
				push_load($urandom_range(0, GLYPH_COUNT - 1), $urandom_range(0, 255));
			else if (pick < 18)
				push_load($urandom_range(GLYPH_COUNT, 127), $urandom_range(0, 255));
			else if (pick < 45)
				push_grey($urandom_range(0, 255));
			else if (pick < 55)
				push_pixel($urandom_range(240, 255), $urandom_range(240, 255),
					$urandom_range(240, 255));
			else
				push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
		end
	end

	// sender: presents items from the queue, holds them until transfer
	always @(posedge clk or negedge arst_n) begin : sender
		work_item_t nxt;
		bit         took;
		bit         offer;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			took = item_valid && item_ready;
			if (took) begin
				absorb_item();
				items_accepted++;
			end
			if (!item_valid || took) begin
				offer = 1'b0;
				// pause until every expected glyph has come back
				if (pending_items.size() > 0 && pending_items[0].drain && !took
						&& glyph_expect.size() == 0 && !glyph_valid)
					void'(pending_items.pop_front());
				if (pending_items.size() > 0 && !pending_items[0].drain
						&& (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_items.pop_front();
					offer = 1'b1;
					mode <= nxt.kind;
					entry_index <= nxt.idx;
					entry_value <= nxt.val;
					blue <= nxt.b;
					green <= nxt.g;
					red <= nxt.r;
				end
				item_valid <= offer;
			end
		end
	end

	// receiver: checks each glyph transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : receiver
		logic [GLYPH_W-1:0] want;
		if (!arst_n) begin
			glyph_ready <= 1'b0;
		end else begin
			if (glyph_valid && glyph_ready) begin
				glyphs_seen++;
				if (glyph_expect.size() == 0) begin
					report_mismatch($sformatf("glyph %0d with nothing expected", glyph));
				end else begin
					want = glyph_expect.pop_front();
					if (glyph !== want)
						report_mismatch($sformatf("glyph %0d, expected %0d", glyph, want));
					if (want == SPACE_GLYPH)
						white_glyphs++;
				end
			end
			// one long hold-off so the pipe fills and input backs up
			if (!held_off && glyphs_seen >= 40) begin
				held_off = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				glyph_ready <= 1'b0;
			end else begin
				glyph_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (glyph_valid && glyph_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// reset, then wait for the stimulus and the glyphs to run out
	initial begin : run_control
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !item_valid);
		wait (glyph_expect.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (glyph_expect.size() != 0)
			report_mismatch($sformatf("%0d glyphs never arrived", glyph_expect.size()));
		$display("Covered %0d table writes, %0d out-of-range writes, %0d pixels",
			loads_taken, loads_dropped, pixels_taken);
		$display("Checked %0d glyphs (%0d white) across sparse, ramp and random tables",
			glyphs_seen, white_glyphs);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
